@@ src/hv_contactor_precharge_sequencer_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the contactor precharge sequencer
// Concurrent checks that compile away when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef HV_CONTACTOR_PRECHARGE_SEQUENCER_MACROS_SVH
`define HV_CONTACTOR_PRECHARGE_SEQUENCER_MACROS_SVH

`ifndef NO_ASSERTIONS
`define HVCPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hvcps: same-cycle check failed");
`define HVCPS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hvcps: next-cycle check failed");
`else
`define HVCPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define HVCPS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ src/hvcps_pkg.sv @@
// ----------------------------------------------------------------------------
// Contactor precharge sequencer package
// Operation codes, result codes, failure bits and register indexes.
// ----------------------------------------------------------------------------
package hvcps_pkg;

  localparam int unsigned OP_W   = 3;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned ST_W   = 2;
  localparam int unsigned TICK_W = 16;
  localparam int unsigned IDX_W  = 3;
  localparam int unsigned CFG_W  = 16;

  typedef logic [OP_W-1:0]   op_t;
  typedef logic [KIND_W-1:0] kind_t;
  typedef logic [ST_W-1:0]   status_t;
  typedef logic [TICK_W-1:0] tick_t;
  typedef logic [IDX_W-1:0]  cfg_idx_t;

  localparam op_t OP_TICK      = 3'd0;
  localparam op_t OP_PRECHARGE = 3'd1;
  localparam op_t OP_CLOSE     = 3'd2;
  localparam op_t OP_OPEN      = 3'd3;
  localparam op_t OP_DROP_PRE  = 3'd4;

  localparam kind_t KIND_PRECHARGE = 2'd0;
  localparam kind_t KIND_CLOSE     = 2'd1;
  localparam kind_t KIND_OPEN      = 2'd2;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_FAIL  = 2'd1;
  localparam status_t FAIL_POS = 2'h1;
  localparam status_t FAIL_NEG = 2'h2;

  localparam cfg_idx_t REG_CLOSE_WAIT = 3'd0;
  localparam cfg_idx_t REG_OPEN_WAIT  = 3'd1;
  localparam cfg_idx_t REG_PRE_WAIT   = 3'd2;
  localparam cfg_idx_t REG_CHK_RELAYS = 3'd3;
  localparam cfg_idx_t REG_CHK_BUS    = 3'd4;

  localparam tick_t CLOSE_WAIT_RST = 16'd500;
  localparam tick_t OPEN_WAIT_RST  = 16'd500;
  localparam tick_t PRE_WAIT_RST   = 16'd5000;

  typedef struct packed {
    logic    pos_drive;
    logic    neg_drive;
    logic    precharge_drive;
    logic    busy;
    logic    done;
    kind_t   done_kind;
    status_t status;
  } result_t;

endpackage

@@ src/hv_contactor_precharge_sequencer.sv @@
// ----------------------------------------------------------------------------
// HV contactor precharge sequencer
// Timed precharge, close-both and open-both sequences over three relay drives.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | operation, feedbacks, bus flag
//  out_    | output    | out_valid/out_stall| drives, busy, done, kind, status
//  cfg_    | input     | cfg_wr_en          | cfg_index, cfg_data
//
//  One item a cycle while in_stall is low: the sequencer state and the
//  result register update at the edge that accepts an item.
//  in_stall is high only while a result waits and out_stall is high.
//  Synchronous active-low reset clears relay state and loads register defaults.
// ----------------------------------------------------------------------------
`include "hv_contactor_precharge_sequencer_macros.svh"

module hv_contactor_precharge_sequencer (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  hvcps_pkg::cfg_idx_t             cfg_index,
  input  logic [hvcps_pkg::CFG_W-1:0]     cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  hvcps_pkg::op_t                  in_operation,
  input  logic                            in_pos_feedback,
  input  logic                            in_neg_feedback,
  input  logic                            in_bus_charged,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_pos_drive,
  output logic                            out_neg_drive,
  output logic                            out_precharge_drive,
  output logic                            out_busy_res,
  output logic                            out_done_res,
  output hvcps_pkg::kind_t                out_done_kind,
  output hvcps_pkg::status_t              out_status
);
  import hvcps_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_PC_NEG,
    PH_PC_PRE,
    PH_PC_POS,
    PH_CLOSE,
    PH_OPEN
  } phase_t;

  tick_t   close_wait_r, open_wait_r, pre_wait_r;
  logic    chk_relays_r, chk_bus_r;

  phase_t  phase_r, phase_nxt;
  tick_t   wait_r, wait_nxt;
  logic    pos_r, pos_nxt;
  logic    neg_r, neg_nxt;
  logic    pre_r, pre_nxt;

  logic    out_valid_r;
  result_t res_r, res_nxt;
  logic    accept;

  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      close_wait_r <= CLOSE_WAIT_RST;
      open_wait_r  <= OPEN_WAIT_RST;
      pre_wait_r   <= PRE_WAIT_RST;
      chk_relays_r <= 1'b1;
      chk_bus_r    <= 1'b1;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_CLOSE_WAIT: close_wait_r <= cfg_data[TICK_W-1:0];
        REG_OPEN_WAIT:  open_wait_r  <= cfg_data[TICK_W-1:0];
        REG_PRE_WAIT:   pre_wait_r   <= cfg_data[TICK_W-1:0];
        REG_CHK_RELAYS: chk_relays_r <= cfg_data[0];
        REG_CHK_BUS:    chk_bus_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    logic    done;
    kind_t   kind;
    status_t st;
    phase_nxt = phase_r;
    wait_nxt  = wait_r;
    pos_nxt   = pos_r;
    neg_nxt   = neg_r;
    pre_nxt   = pre_r;
    done      = 1'b0;
    kind      = KIND_PRECHARGE;
    st        = ST_OK;
    if (phase_r == PH_IDLE) begin
      case (in_operation)
        OP_PRECHARGE: begin
          neg_nxt   = 1'b1;
          wait_nxt  = close_wait_r;
          phase_nxt = PH_PC_NEG;
        end
        OP_CLOSE: begin
          pos_nxt   = 1'b1;
          neg_nxt   = 1'b1;
          wait_nxt  = close_wait_r;
          phase_nxt = PH_CLOSE;
        end
        OP_OPEN: begin
          pos_nxt   = 1'b0;
          neg_nxt   = 1'b0;
          wait_nxt  = open_wait_r;
          phase_nxt = PH_OPEN;
        end
        OP_DROP_PRE: pre_nxt = 1'b0;
        default: ;
      endcase
    end else if (wait_r != '0) begin
      wait_nxt = wait_r - tick_t'(1);
    end else begin
      case (phase_r)
        PH_PC_NEG: begin
          if (chk_relays_r && !in_neg_feedback) begin
            pos_nxt   = 1'b0;
            neg_nxt   = 1'b0;
            done      = 1'b1;
            st        = ST_FAIL;
            phase_nxt = PH_IDLE;
          end else begin
            pre_nxt   = 1'b1;
            wait_nxt  = pre_wait_r;
            phase_nxt = PH_PC_PRE;
          end
        end
        PH_PC_PRE: begin
          if (!chk_bus_r || in_bus_charged) begin
            pos_nxt   = 1'b1;
            wait_nxt  = close_wait_r;
            phase_nxt = PH_PC_POS;
          end else begin
            pre_nxt   = 1'b0;
            done      = 1'b1;
            st        = ST_FAIL;
            phase_nxt = PH_IDLE;
          end
        end
        PH_PC_POS: begin
          pre_nxt   = 1'b0;
          done      = 1'b1;
          phase_nxt = PH_IDLE;
        end
        PH_CLOSE: begin
          if (chk_relays_r) begin
            if (!in_pos_feedback) st = st | FAIL_POS;
            if (!in_neg_feedback) st = st | FAIL_NEG;
            if (st != ST_OK) begin
              pos_nxt = 1'b0;
              neg_nxt = 1'b0;
            end
          end
          done      = 1'b1;
          kind      = KIND_CLOSE;
          phase_nxt = PH_IDLE;
        end
        PH_OPEN: begin
          if (in_pos_feedback) st = st | FAIL_POS;
          if (in_neg_feedback) st = st | FAIL_NEG;
          pos_nxt   = 1'b0;
          neg_nxt   = 1'b0;
          done      = 1'b1;
          kind      = KIND_OPEN;
          phase_nxt = PH_IDLE;
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end
    res_nxt.pos_drive       = pos_nxt;
    res_nxt.neg_drive       = neg_nxt;
    res_nxt.precharge_drive = pre_nxt;
    res_nxt.busy            = (phase_nxt != PH_IDLE);
    res_nxt.done            = done;
    res_nxt.done_kind       = done ? kind : KIND_PRECHARGE;
    res_nxt.status          = done ? st : ST_OK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      wait_r      <= '0;
      pos_r       <= 1'b0;
      neg_r       <= 1'b0;
      pre_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r <= phase_nxt;
        wait_r  <= wait_nxt;
        pos_r   <= pos_nxt;
        neg_r   <= neg_nxt;
        pre_r   <= pre_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_pos_drive       = res_r.pos_drive;
  assign out_neg_drive       = res_r.neg_drive;
  assign out_precharge_drive = res_r.precharge_drive;
  assign out_busy_res        = res_r.busy;
  assign out_done_res        = res_r.done;
  assign out_done_kind       = res_r.done_kind;
  assign out_status          = res_r.status;

  `HVCPS_ASSERT_IMP(a_done_not_busy, clk, rst_n, out_valid_r && res_r.done, !res_r.busy)
  `HVCPS_ASSERT_IMP(a_quiet_codes, clk, rst_n, out_valid_r && !res_r.done, (res_r.done_kind == KIND_PRECHARGE) && (res_r.status == ST_OK))
  `HVCPS_ASSERT_IMP(a_pos_needs_neg, clk, rst_n, out_valid_r && res_r.pos_drive, res_r.neg_drive)
  `HVCPS_ASSERT_NXT(a_wait_countdown, clk, rst_n, accept && (phase_r != PH_IDLE) && (wait_r != '0), (wait_r == $past(wait_r) - tick_t'(1)) && (phase_r == $past(phase_r)))

endmodule

@@ dv/hv_contactor_precharge_sequencer_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// HV contactor precharge sequencer testbench
// Sends timer ticks that carry relay feedback and the bus flag, mirrors the
// relay sequencing in a scoreboard and checks every result field by field.
// Runs directed sequences, random sequences under several register settings,
// a long output hold-off and long waits.
// ----------------------------------------------------------------------------
module hv_contactor_precharge_sequencer_tb;
  import hvcps_pkg::*;

  localparam int IDLE_PCT    = 37;
  localparam int HOLD_CYCLES = 80;
  localparam int PHASE_ITEMS = 90;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_NEG_CHECK,
    SEQ_BUS_CHECK,
    SEQ_POS_SETTLE,
    SEQ_CLOSE,
    SEQ_OPEN
  } seq_phase_e;

  class contactor_scoreboard;
    tick_t      close_wait = CLOSE_WAIT_RST;
    tick_t      open_wait  = OPEN_WAIT_RST;
    tick_t      pre_wait   = PRE_WAIT_RST;
    logic       chk_relays = 1'b1;
    logic       chk_bus    = 1'b1;
    seq_phase_e seq        = SEQ_IDLE;
    tick_t      count      = '0;
    logic       pos_q      = 1'b0;
    logic       neg_q      = 1'b0;
    logic       pre_q      = 1'b0;
    result_t    expected_drives[$];
    int         errors     = 0;

    function void apply_reg(cfg_idx_t idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_CLOSE_WAIT: close_wait = data;
        REG_OPEN_WAIT:  open_wait  = data;
        REG_PRE_WAIT:   pre_wait   = data;
        REG_CHK_RELAYS: chk_relays = data[0];
        REG_CHK_BUS:    chk_bus    = data[0];
        default: ;
      endcase
    endfunction

    function void note_tick(op_t op, logic pos_fb, logic neg_fb, logic bus);
      result_t r;
      r.done      = 1'b0;
      r.done_kind = KIND_PRECHARGE;
      r.status    = ST_OK;
      if (seq == SEQ_IDLE) begin
        case (op)
          OP_PRECHARGE: begin
            neg_q = 1'b1;
            count = close_wait;
            seq   = SEQ_NEG_CHECK;
          end
          OP_CLOSE: begin
            pos_q = 1'b1;
            neg_q = 1'b1;
            count = close_wait;
            seq   = SEQ_CLOSE;
          end
          OP_OPEN: begin
            pos_q = 1'b0;
            neg_q = 1'b0;
            count = open_wait;
            seq   = SEQ_OPEN;
          end
          OP_DROP_PRE: pre_q = 1'b0;
          default: ;
        endcase
      end else if (count != '0) begin
        count = count - tick_t'(1);
      end else begin
        r.done = 1'b1;
        case (seq)
          SEQ_NEG_CHECK: begin
            if (chk_relays && !neg_fb) begin
              pos_q    = 1'b0;
              neg_q    = 1'b0;
              r.status = ST_FAIL;
              seq      = SEQ_IDLE;
            end else begin
              r.done = 1'b0;
              pre_q  = 1'b1;
              count  = pre_wait;
              seq    = SEQ_BUS_CHECK;
            end
          end
          SEQ_BUS_CHECK: begin
            if (!chk_bus || bus) begin
              r.done = 1'b0;
              pos_q  = 1'b1;
              count  = close_wait;
              seq    = SEQ_POS_SETTLE;
            end else begin
              pre_q    = 1'b0;
              r.status = ST_FAIL;
              seq      = SEQ_IDLE;
            end
          end
          SEQ_POS_SETTLE: begin
            pre_q = 1'b0;
            seq   = SEQ_IDLE;
          end
          SEQ_CLOSE: begin
            r.done_kind = KIND_CLOSE;
            if (chk_relays) begin
              if (!pos_fb) r.status = r.status | FAIL_POS;
              if (!neg_fb) r.status = r.status | FAIL_NEG;
              if (r.status != ST_OK) begin
                pos_q = 1'b0;
                neg_q = 1'b0;
              end
            end
            seq = SEQ_IDLE;
          end
          SEQ_OPEN: begin
            r.done_kind = KIND_OPEN;
            if (pos_fb) r.status = r.status | FAIL_POS;
            if (neg_fb) r.status = r.status | FAIL_NEG;
            pos_q = 1'b0;
            neg_q = 1'b0;
            seq   = SEQ_IDLE;
          end
          default: begin
            r.done = 1'b0;
            seq    = SEQ_IDLE;
          end
        endcase
      end
      r.pos_drive       = pos_q;
      r.neg_drive       = neg_q;
      r.precharge_drive = pre_q;
      r.busy            = (seq != SEQ_IDLE);
      expected_drives.push_back(r);
    endfunction

    function void check_field(string name, logic [1:0] exp_v, logic [1:0] got_v);
      if (got_v !== exp_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_drives(result_t got);
      result_t exp_r;
      if (expected_drives.size() == 0) begin
        $error("result item with no tick outstanding");
        errors++;
        return;
      end
      exp_r = expected_drives.pop_front();
      check_field("pos_drive", 2'(exp_r.pos_drive), 2'(got.pos_drive));
      check_field("neg_drive", 2'(exp_r.neg_drive), 2'(got.neg_drive));
      check_field("precharge_drive", 2'(exp_r.precharge_drive),
                  2'(got.precharge_drive));
      check_field("busy_res", 2'(exp_r.busy), 2'(got.busy));
      check_field("done_res", 2'(exp_r.done), 2'(got.done));
      check_field("done_kind", exp_r.done_kind, got.done_kind);
      check_field("status", exp_r.status, got.status);
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_wr_en = 1'b0;
  cfg_idx_t         cfg_index = REG_CLOSE_WAIT;
  logic [CFG_W-1:0] cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  op_t              in_operation = OP_TICK;
  logic             in_pos_feedback = 1'b0;
  logic             in_neg_feedback = 1'b0;
  logic             in_bus_charged = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic             out_pos_drive;
  logic             out_neg_drive;
  logic             out_precharge_drive;
  logic             out_busy_res;
  logic             out_done_res;
  kind_t            out_done_kind;
  status_t          out_status;

  contactor_scoreboard sb = new();
  logic steady = 1'b0;
  logic hold_armed = 1'b0;
  logic hold_done = 1'b0;
  int   hold_left = 0;

  hv_contactor_precharge_sequencer uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_operation        (in_operation),
    .in_pos_feedback     (in_pos_feedback),
    .in_neg_feedback     (in_neg_feedback),
    .in_bus_charged      (in_bus_charged),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_pos_drive       (out_pos_drive),
    .out_neg_drive       (out_neg_drive),
    .out_precharge_drive (out_precharge_drive),
    .out_busy_res        (out_busy_res),
    .out_done_res        (out_done_res),
    .out_done_kind       (out_done_kind),
    .out_status          (out_status)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall)
        sb.check_drives(result_t'({out_pos_drive, out_neg_drive, out_precharge_drive,
                                   out_busy_res, out_done_res, out_done_kind,
                                   out_status}));
      if (hold_armed && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  task automatic send_tick(op_t op, logic pos_fb, logic neg_fb, logic bus);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_operation    <= op;
    in_pos_feedback <= pos_fb;
    in_neg_feedback <= neg_fb;
    in_bus_charged  <= bus;
    do @(posedge clk); while (in_stall);
    sb.note_tick(op, pos_fb, neg_fb, bus);
  endtask

  task automatic random_tick();
    op_t  op;
    logic good;
    int   cmd_pct;
    cmd_pct = (sb.seq == SEQ_IDLE) ? 45 : 8;
    if ($urandom_range(99) < cmd_pct)
      op = op_t'($urandom_range(OP_PRECHARGE, OP_DROP_PRE));
    else if ($urandom_range(99) < 6)
      op = op_t'($urandom_range(OP_DROP_PRE + 1, op_t'('1)));
    else
      op = OP_TICK;
    // bias feedback towards what lets the sequence pass its checks
    good = ($urandom_range(99) < 80);
    send_tick(op,
              good ? (sb.seq != SEQ_OPEN) : 1'($urandom_range(1)),
              good ? (sb.seq != SEQ_OPEN) : 1'($urandom_range(1)),
              good ? 1'b1 : 1'($urandom_range(1)));
  endtask

  task automatic run_op(op_t op, logic pos_fb, logic neg_fb, logic bus);
    send_tick(op, pos_fb, neg_fb, bus);
    while (sb.seq != SEQ_IDLE)
      send_tick(OP_TICK, pos_fb, neg_fb, bus);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_drives.size() != 0)
      @(posedge clk);
  endtask

  task automatic settle();
    while (sb.seq != SEQ_IDLE)
      send_tick(OP_TICK, 1'($urandom_range(1)), 1'($urandom_range(1)),
                1'($urandom_range(1)));
    drain();
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.apply_reg(idx, data);
  endtask

  task automatic load_regs(logic [CFG_W-1:0] close_w, logic [CFG_W-1:0] open_w,
                           logic [CFG_W-1:0] pre_w, logic [CFG_W-1:0] chk_r,
                           logic [CFG_W-1:0] chk_b);
    write_reg(REG_CLOSE_WAIT, close_w);
    write_reg(REG_OPEN_WAIT, open_w);
    write_reg(REG_PRE_WAIT, pre_w);
    write_reg(REG_CHK_RELAYS, chk_r);
    write_reg(REG_CHK_BUS, chk_b);
    write_reg(cfg_idx_t'(REG_CHK_BUS + 1 + $urandom_range(2)), 16'($urandom()));
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [CFG_W-1:0] short_wait();
    return ($urandom_range(99) < 25) ? '0 : tick_t'($urandom_range(1, 4));
  endfunction

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    run_op(OP_CLOSE, 1'b1, 1'b1, 1'b1);
    settle();

    load_regs('0, '0, '0, 16'h0001, 16'h0001);
    run_op(OP_PRECHARGE, 1'b1, 1'b1, 1'b1);
    run_op(OP_PRECHARGE, 1'b1, 1'b0, 1'b1);
    run_op(OP_PRECHARGE, 1'b1, 1'b1, 1'b0);
    run_op(OP_CLOSE, 1'b1, 1'b1, 1'b1);
    run_op(OP_CLOSE, 1'b0, 1'b1, 1'b1);
    run_op(OP_CLOSE, 1'b1, 1'b0, 1'b1);
    run_op(OP_OPEN, 1'b0, 1'b0, 1'b1);
    run_op(OP_OPEN, 1'b1, 1'b1, 1'b0);
    for (int v = OP_DROP_PRE; v <= int'(op_t'('1)); v++)
      send_tick(op_t'(v), 1'b0, 1'b0, 1'b0);
    // commands while a precharge runs are dropped
    send_tick(OP_PRECHARGE, 1'b1, 1'b1, 1'b1);
    send_tick(OP_CLOSE, 1'b1, 1'b1, 1'b1);
    send_tick(OP_OPEN, 1'b1, 1'b1, 1'b1);
    send_tick(OP_DROP_PRE, 1'b1, 1'b1, 1'b1);
    settle();

    load_regs('0, '0, '0, 16'h0000, 16'h0001);
    run_op(OP_CLOSE, 1'b0, 1'b0, 1'b0);
    run_op(OP_PRECHARGE, 1'b0, 1'b0, 1'b1);
    settle();

    load_regs('0, '0, '0, 16'h0001, 16'h0000);
    run_op(OP_PRECHARGE, 1'b1, 1'b1, 1'b0);
    settle();

    for (int ph = 0; ph < 6; ph++) begin
      steady = (ph == 3);
      load_regs(short_wait(), short_wait(), short_wait(), 16'($urandom()),
                16'($urandom()));
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == 1 && k == PHASE_ITEMS / 2)
          drain();
        if (ph == 2 && k == 20)
          hold_armed = 1'b1;
        random_tick();
      end
      settle();
    end

    // long waits, run without idling
    steady = 1'b1;
    load_regs(16'd40, '0, '0, '1, 16'h0001);
    run_op(OP_CLOSE, 1'b1, 1'b1, 1'b1);
    settle();
    load_regs('0, 16'd40, 16'd40, 16'hFFFE, '1);
    run_op(OP_OPEN, 1'b0, 1'b0, 1'b1);
    run_op(OP_PRECHARGE, 1'b1, 1'b1, 1'b1);
    settle();
    steady = 1'b0;

    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.expected_drives.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
